// ----- design/sigma_clip_frame_defines.svh -----
// Assertion macros for the sigma clipping frame block.
// Included by the top level; relies on clk and arst_n in the including scope.
`ifndef SIGMA_CLIP_FRAME_DEFINES_SVH
`define SIGMA_CLIP_FRAME_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SCF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sigma_clip_frame assertion failed");

// Next-cycle implication, checked out of reset.
`define SCF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sigma_clip_frame assertion failed");

`endif

// ----- design/scf_pkg.sv -----
// Shared constants for the sigma clipping frame block.
// No dependencies; imported by sigma_clip_frame.
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;
	localparam int PIX_W      = 20;
	localparam int MAX_PIXELS = 65536;
	localparam int ADDR_W     = $clog2(MAX_PIXELS);
	localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
	localparam int SUM_W      = PIX_W + CNT_W;
	localparam int ACC_W      = 64;
	localparam int CW_W       = 4;
	localparam int SIGMA_W    = ACC_W / 2;
	localparam int SPREAD_W   = SIGMA_W + CW_W;
	localparam int BND_W      = SPREAD_W + 2;
	localparam int DIV_STEPS  = ACC_W;
	localparam int SQRT_STEPS = ACC_W / 2;

	localparam logic [CW_W-1:0]  CLIP_RESET = 4'd4;
	localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(MAX_PIXELS);
	localparam logic signed [PIX_W-1:0] PIX_MAX = 20'sd524287;
	localparam logic signed [PIX_W-1:0] PIX_MIN = -20'sd524288;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;
endpackage

`default_nettype wire

// ----- design/sigma_clip_frame.sv -----
// Sigma clipping of one stored frame: top level with frame memory and sequencer.
// Depends on scf_pkg and sigma_clip_frame_defines.svh.
//
// Usage:
//  Input beats carry tuser = operation (0 load, 1 read) and tdata = pixel.
//  A load beat writes the pixel into the frame memory; a load after readout
//  has begun starts a new frame. Loads beyond the memory depth are dropped.
//  A read beat returns one output beat: tdata = clipped pixel, tlast = final
//  pixel of the frame, tuser = overrun (no unread pixel left, data zero).
//  A read whose bounds are ready reads its pixel when accepted and presents
//  its output beat from the clip state once the output register is free.
//  The first read of a frame first computes the bounds: a 64-step shared
//  restoring divider for the mean, one pass over the memory (one read port),
//  another 64-step divide for the variance (skipped below two pixels) and
//  32 steps of square root, then saturates the bounds and reads the pixel.
//  The output beat sits in a register; new loads are accepted while it
//  waits, and a following read holds in its clip state until it is taken.
//  Reset clears counts, sums, bounds and sets the clip width to four; the
//  memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "sigma_clip_frame_defines.svh"

module sigma_clip_frame
	import scf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [19:0] pixel_value, [23:20] zero
	input  wire logic        s_tuser,   // [0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // [19:0] clipped_value, [23:20] zero
	output logic             m_tlast,
	output logic             m_tuser,   // [0] overrun
	input  wire logic        cfg_wr_en,
	input  wire logic [3:0]  cfg_wr_data
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV_MEAN, ST_SQ_PASS, ST_DIV_VAR, ST_SQRT, ST_BOUNDS, ST_CLIP, ST_OVR
	} state_t;

	state_t state_q;

	logic [CW_W-1:0]         clip_width_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [PIX_W-1:0] upper_q, lower_q, mean_q;
	logic [CNT_W-1:0]        rd_ptr_q;
	logic                    ready_q;

	// Shared divider and square-root registers.
	logic [ACC_W-1:0] div_q_q;
	logic [CNT_W-1:0] div_rem_q, div_den_q;
	logic [6:0]       div_cnt_q;
	logic             sum_neg_q;
	logic [ACC_W-1:0] sq_v_q, sq_res_q, sq_bit_q;
	logic [4:0]       sq_cnt_q;

	// Squared deviation pass.
	logic [CNT_W-1:0]        sq_idx_q;
	logic                    valid_s1, valid_s2, valid_s3;
	logic signed [PIX_W:0]   dev_s2;
	logic [2*PIX_W+1:0]      sqr_s3;
	logic [ACC_W-1:0]        acc_q;

	// Frame memory.
	logic [PIX_W-1:0] mem [MAX_PIXELS];
	logic [PIX_W-1:0] mem_rd_q;
	logic             mem_we, mem_re;
	logic [ADDR_W-1:0] mem_wa, mem_ra;

	logic              acc_in, is_load, is_read, out_free;
	logic signed [PIX_W-1:0] px_in;

	assign s_tready = (state_q == ST_IDLE);
	assign acc_in   = s_tvalid && s_tready;
	assign is_load  = acc_in && (s_tuser == OP_LOAD);
	assign is_read  = acc_in && (s_tuser == OP_READ);
	assign px_in    = s_tdata[PIX_W-1:0];
	assign out_free = !m_tvalid || m_tready;

	// Memory write on load, read for the deviation pass and readout.
	always_comb begin
		mem_we = is_load && (ready_q || count_q != COUNT_FULL);
		mem_wa = ready_q ? '0 : count_q[ADDR_W-1:0];
		mem_re = 1'b0;
		mem_ra = rd_ptr_q[ADDR_W-1:0];
		case (state_q)
			ST_IDLE: begin
				mem_re = is_read && ready_q && rd_ptr_q < count_q;
			end
			ST_SQ_PASS: begin
				mem_re = sq_idx_q != count_q;
				mem_ra = sq_idx_q[ADDR_W-1:0];
			end
			ST_BOUNDS: mem_re = 1'b1;
			default: mem_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= px_in;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_ra];
		end
	end

	// One restoring divide step.
	logic [CNT_W:0]   div_trial;
	logic             div_take;
	logic [CNT_W-1:0] div_rem_nx;
	logic [ACC_W-1:0] div_q_nx;
	always_comb begin
		div_trial  = {div_rem_q, div_q_q[ACC_W-1]};
		div_take   = div_trial >= {1'b0, div_den_q};
		div_rem_nx = div_take ? CNT_W'(div_trial - {1'b0, div_den_q}) : div_trial[CNT_W-1:0];
		div_q_nx   = {div_q_q[ACC_W-2:0], div_take};
	end

	// One square-root digit step.
	logic [ACC_W-1:0] sq_sum;
	logic             sq_take;
	always_comb begin
		sq_sum  = sq_res_q + sq_bit_q;
		sq_take = sq_v_q >= sq_sum;
	end

	// Bounds from mean and sigma.
	logic [SPREAD_W-1:0]     spread;
	logic signed [BND_W-1:0] hi_w, lo_w;
	always_comb begin
		spread = SPREAD_W'(clip_width_q) * SPREAD_W'(sq_res_q[SIGMA_W-1:0]);
		hi_w   = BND_W'(mean_q) + $signed({2'b00, spread});
		lo_w   = BND_W'(mean_q) - $signed({2'b00, spread});
	end

	// Clamp of the read pixel.
	logic signed [PIX_W-1:0] clip_v;
	always_comb begin
		clip_v = mem_rd_q;
		if (clip_v > upper_q) clip_v = upper_q;
		if (clip_v < lower_q) clip_v = lower_q;
	end

	// Sequencer with state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			clip_width_q <= CLIP_RESET;
			count_q      <= '0;
			sum_q        <= '0;
			upper_q      <= '0;
			lower_q      <= '0;
			rd_ptr_q     <= '0;
			ready_q      <= 1'b0;
			m_tvalid     <= 1'b0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				clip_width_q <= cfg_wr_data;
			end
			if (m_tvalid && m_tready && state_q != ST_CLIP && state_q != ST_OVR) begin
				m_tvalid <= 1'b0;
			end
			valid_s1 <= (state_q == ST_SQ_PASS) && (sq_idx_q != count_q);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			case (state_q)
				ST_IDLE: begin
					if (is_load) begin
						if (ready_q) begin
							count_q  <= CNT_W'(1);
							sum_q    <= SUM_W'(px_in);
							rd_ptr_q <= '0;
							ready_q  <= 1'b0;
						end else if (count_q != COUNT_FULL) begin
							count_q <= count_q + 1'b1;
							sum_q   <= sum_q + SUM_W'(px_in);
						end
					end else if (is_read) begin
						if (count_q == '0 || rd_ptr_q >= count_q) begin
							state_q <= ST_OVR;
						end else if (ready_q) begin
							state_q <= ST_CLIP;
						end else begin
							sum_neg_q <= sum_q[SUM_W-1];
							div_q_q   <= ACC_W'(sum_q[SUM_W-1] ? -sum_q : sum_q);
							div_rem_q <= '0;
							div_den_q <= count_q;
							div_cnt_q <= '0;
							state_q   <= ST_DIV_MEAN;
						end
					end
				end
				ST_DIV_MEAN: begin
					div_q_q   <= div_q_nx;
					div_rem_q <= div_rem_nx;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 7'(DIV_STEPS - 1)) begin
						mean_q   <= sum_neg_q ? -div_q_nx[PIX_W-1:0] : div_q_nx[PIX_W-1:0];
						sq_idx_q <= '0;
						acc_q    <= '0;
						state_q  <= ST_SQ_PASS;
					end
				end
				ST_SQ_PASS: begin
					// Read, subtract, square and accumulate in a short pipeline.
					if (sq_idx_q != count_q) begin
						sq_idx_q <= sq_idx_q + 1'b1;
					end
					dev_s2 <= $signed({mem_rd_q[PIX_W-1], mem_rd_q}) -
						$signed({mean_q[PIX_W-1], mean_q});
					sqr_s3 <= $unsigned((2*PIX_W+2)'(dev_s2) * (2*PIX_W+2)'(dev_s2));
					if (valid_s3) begin
						acc_q <= acc_q + ACC_W'(sqr_s3);
					end
					if (sq_idx_q == count_q && !valid_s1 && !valid_s2 && !valid_s3) begin
						div_q_q   <= acc_q;
						div_rem_q <= '0;
						div_den_q <= count_q - 1'b1;
						div_cnt_q <= '0;
						if (count_q < CNT_W'(2)) begin
							sq_v_q   <= '0;
							sq_res_q <= '0;
							sq_bit_q <= ACC_W'(1) << (ACC_W - 2);
							sq_cnt_q <= '0;
							state_q  <= ST_SQRT;
						end else begin
							state_q <= ST_DIV_VAR;
						end
					end
				end
				ST_DIV_VAR: begin
					div_q_q   <= div_q_nx;
					div_rem_q <= div_rem_nx;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 7'(DIV_STEPS - 1)) begin
						sq_v_q   <= div_q_nx;
						sq_res_q <= '0;
						sq_bit_q <= ACC_W'(1) << (ACC_W - 2);
						sq_cnt_q <= '0;
						state_q  <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sq_take) begin
						sq_v_q   <= sq_v_q - sq_sum;
						sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
					end else begin
						sq_res_q <= sq_res_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == 5'(SQRT_STEPS - 1)) begin
						state_q <= ST_BOUNDS;
					end
				end
				ST_BOUNDS: begin
					// Saturate the bounds; the first pixel read is issued here.
					upper_q <= (hi_w > BND_W'(PIX_MAX)) ? PIX_MAX : hi_w[PIX_W-1:0];
					lower_q <= (lo_w < BND_W'(PIX_MIN)) ? PIX_MIN : lo_w[PIX_W-1:0];
					ready_q <= 1'b1;
					state_q <= ST_CLIP;
				end
				ST_CLIP: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {4'h0, clip_v};
						m_tlast  <= (rd_ptr_q + 1'b1) == count_q;
						m_tuser  <= 1'b0;
						rd_ptr_q <= rd_ptr_q + 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_OVR: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= '0;
						m_tlast  <= 1'b0;
						m_tuser  <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Overrun beats carry zero data and never end a frame.
	`SCF_ASSERT_NOW(a_ovr_zero, m_tvalid && m_tuser, m_tdata == '0 && !m_tlast)
	// Bounds, once fixed, are ordered.
	`SCF_ASSERT_NOW(a_bounds_order, ready_q && state_q == ST_IDLE, lower_q <= upper_q)
	// The read pointer never passes the frame length.
	`SCF_ASSERT_NOW(a_ptr_range, 1'b1, rd_ptr_q <= count_q)
	// A clipped beat is presented the cycle after the clip state completes.
	`SCF_ASSERT_NEXT(a_clip_out, state_q == ST_CLIP && out_free, m_tvalid && !m_tuser)

endmodule

`default_nettype wire
